// ===== rtl/core/sha256_byte_stream_hasher_unit_macros.svh =====
// Assertion macros shared by the hasher modules.
`ifndef SHA256_BYTE_STREAM_HASHER_UNIT_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_UNIT_MACROS_SVH
// Checks that a condition implies a consequence in the same cycle.
`define SHA_ASSERT_IMP(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);
// Checks that a condition implies a consequence in the next cycle.
`define SHA_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/core/sha_pkg.sv =====
package sha_pkg;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned Rounds     = 64;
    localparam int unsigned LenOffset  = 56;
    localparam logic [7:0]  PadByte    = 8'h80;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       byte_valid;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_LEN,
        ST_EMIT
    } t_state;

    // Phases of the compression core.
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FETCH,
        PH_RUN,
        PH_FOLD
    } t_core_phase;

    // Control from sequencer to compression core.
    typedef struct packed {
        logic start;
    } t_core_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_sts;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        k = 32'h0;
        case (idx)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] idx);
        logic [31:0] h;
        case (idx)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== rtl/core/sha_stream_if.sv =====
interface sha_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/sha_core.sv =====
`include "sha256_byte_stream_hasher_unit_macros.svh"

// Compression core. The chaining value lives in the caller's view as a
// register file here; the message schedule is a 16-word window fed from the
// block memory in the top level, one word a cycle during the fetch phase.
module sha_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha_pkg::t_core_ctl  i_ctl,
    input  logic [31:0]         i_word,
    input  logic                i_restart,
    input  logic [2:0]          i_rd_idx,
    output logic [31:0]         o_rd_word,
    output logic [3:0]          o_word_addr,
    output sha_pkg::t_core_sts  o_sts
);

    // Phases: fetch 16 words from the registered block memory, 64 rounds, fold.
    logic [6:0]            r_cnt, n_cnt;
    sha_pkg::t_core_phase  r_ph, n_ph;
    logic [31:0]  r_w [16];
    logic [31:0]  r_v [8];
    logic [31:0]  r_h [8];
    logic [31:0]  w_new, w_cur, s0, s1, t1, t2, big0, big1, ch, maj;
    logic         done_c;

    assign o_word_addr = r_cnt[3:0];

    always_comb begin
        s0 = sha_pkg::ror(r_w[1], 7) ^ sha_pkg::ror(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = sha_pkg::ror(r_w[14], 17) ^ sha_pkg::ror(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = r_w[0] + s0 + r_w[9] + s1;
        w_cur = r_w[0];
        big1 = sha_pkg::ror(r_v[4], 6) ^ sha_pkg::ror(r_v[4], 11) ^ sha_pkg::ror(r_v[4], 25);
        ch   = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        big0 = sha_pkg::ror(r_v[0], 2) ^ sha_pkg::ror(r_v[0], 13) ^ sha_pkg::ror(r_v[0], 22);
        maj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1 = r_v[7] + big1 + ch + sha_pkg::round_k(r_cnt[5:0]) + w_cur;
        t2 = big0 + maj;
    end

    always_comb begin
        n_ph   = r_ph;
        n_cnt  = r_cnt;
        done_c = 1'b0;
        unique case (r_ph)
            sha_pkg::PH_IDLE: begin
                if (i_ctl.start) begin
                    n_ph  = sha_pkg::PH_FETCH;
                    n_cnt = '0;
                end
            end
            sha_pkg::PH_FETCH: begin
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd16) begin
                    n_ph  = sha_pkg::PH_RUN;
                    n_cnt = '0;
                end
            end
            sha_pkg::PH_RUN: begin
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'(sha_pkg::Rounds - 1)) begin
                    n_ph = sha_pkg::PH_FOLD;
                end
            end
            sha_pkg::PH_FOLD: begin
                n_ph   = sha_pkg::PH_IDLE;
                done_c = 1'b1;
            end
            default: begin
                n_ph = sha_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph  <= sha_pkg::PH_IDLE;
            r_cnt <= '0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= sha_pkg::init_h(3'(i));
            end
        end else begin
            r_ph  <= n_ph;
            r_cnt <= n_cnt;
            if (i_restart) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= sha_pkg::init_h(3'(i));
                end
            end else if (r_ph == sha_pkg::PH_FOLD) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ph == sha_pkg::PH_FETCH && r_cnt != 7'd0) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= i_word;
        end else if (r_ph == sha_pkg::PH_RUN) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= w_new;
        end
        if (r_ph == sha_pkg::PH_FETCH) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_h[i];
            end
        end else if (r_ph == sha_pkg::PH_RUN) begin
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    // During the fold the folded word is forwarded, so a read in the done
    // cycle already sees the new chaining value.
    assign o_rd_word  = (r_ph == sha_pkg::PH_FOLD) ? r_h[i_rd_idx] + r_v[i_rd_idx]
                                                   : r_h[i_rd_idx];
    assign o_sts.busy = (r_ph != sha_pkg::PH_IDLE);
    assign o_sts.done = done_c;

    `SHA_ASSERT_IMP(a_start_idle, i_clk, i_rst_n, i_ctl.start, r_ph == sha_pkg::PH_IDLE,
        "core started while busy")
    `SHA_ASSERT_NEXT(a_fold_done, i_clk, i_rst_n, r_ph == sha_pkg::PH_FOLD,
        r_ph == sha_pkg::PH_IDLE, "fold did not finish")
    `SHA_ASSERT_IMP(a_run_cnt, i_clk, i_rst_n, r_ph == sha_pkg::PH_RUN, r_cnt < 7'd64,
        "round count out of range")

endmodule

// ===== rtl/core/sha256_byte_stream_hasher_unit.sv =====
// SHA-256 hasher over a byte stream.
// Input channel (sha_stream_if sink): byte_value, byte_valid, last. A byte
// with byte_valid set is written into the 64-byte block memory. An item with
// last set finishes the message; an item with neither flag does nothing.
// Output channel (sha_stream_if source): eight transfers per message, the
// digest words in order, word_index 0 to 7, last_word on the eighth.
// Throughput: one byte a cycle while a block fills. When a block is full the
// input stalls for the compression: a fetch of 16 words from the block
// memory, 64 rounds of the single round unit, and one fold. Padding takes
// up to 64 byte writes into the block memory per padding block plus one or
// two compressions; the eight digest words then leave one per transfer.
// The block memory needs no clearing: padding writes every entry that a
// compression reads.
// Reset returns the chaining value to the initial hash values and clears
// the byte count and bit count. If the receiver stalls, the current digest
// word is held on the output register and nothing else proceeds.
`include "sha256_byte_stream_hasher_unit_macros.svh"

module sha256_byte_stream_hasher_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    sha_stream_if.sink   i_in,
    sha_stream_if.source o_out
);

    // Block memory: 16 words of 32 bits, written one byte lane at a time.
    logic [7:0]   r_mem [4][16];
    logic [31:0]  r_rd_data;
    logic [3:0]   mem_raddr;
    logic         mem_we;
    logic [5:0]   mem_waddr;
    logic [7:0]   mem_wdata;

    sha_pkg::t_state    r_state, n_state;
    logic [5:0]         r_fill, n_fill;
    logic [63:0]        r_bits, n_bits;
    logic               r_two, n_two;
    logic [2:0]         r_oidx, n_oidx;
    logic               r_ovalid, n_ovalid;
    logic [31:0]        r_oword, n_oword;
    logic               r_olast, n_olast;
    sha_pkg::t_core_ctl ctl;
    sha_pkg::t_core_sts sts;
    logic               restart;
    logic [31:0]        h_word;
    logic [2:0]         h_idx;
    sha_pkg::t_in_item  item;
    logic               in_fire;

    assign item    = i_in.data;
    assign in_fire = i_in.valid && i_in.ready;

    sha_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_word     (r_rd_data),
        .i_restart  (restart),
        .i_rd_idx   (h_idx),
        .o_rd_word  (h_word),
        .o_word_addr(mem_raddr),
        .o_sts      (sts)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr[1:0]][mem_waddr[5:2]] <= mem_wdata;
        end
        r_rd_data <= {r_mem[0][mem_raddr], r_mem[1][mem_raddr],
                      r_mem[2][mem_raddr], r_mem[3][mem_raddr]};
    end

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_bits    = r_bits;
        n_two     = r_two;
        n_oidx    = r_oidx;
        n_ovalid  = r_ovalid;
        n_oword   = r_oword;
        n_olast   = r_olast;
        ctl.start = 1'b0;
        restart   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_fill;
        mem_wdata = item.byte_value;
        h_idx     = r_oidx;
        i_in.ready = (r_state == sha_pkg::ST_IDLE);
        unique case (r_state)
            sha_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (item.byte_valid) begin
                        mem_we = 1'b1;
                        n_fill = r_fill + 6'd1;
                        n_bits = r_bits + 64'd8;
                    end
                    if (item.byte_valid && r_fill == 6'(sha_pkg::BlockBytes - 1)) begin
                        ctl.start = 1'b1;
                        n_state   = sha_pkg::ST_ROUND;
                        n_two     = item.last;
                    end else if (item.last) begin
                        n_state = sha_pkg::ST_PAD;
                        n_two   = 1'b0;
                    end
                end
            end
            sha_pkg::ST_ROUND: begin
                // A full data block is compressing; r_two marks a pending finish.
                if (sts.done) begin
                    n_state = r_two ? sha_pkg::ST_PAD : sha_pkg::ST_IDLE;
                    n_two   = 1'b0;
                end
            end
            sha_pkg::ST_PAD: begin
                // Write the pad byte at r_fill, then zeros.
                mem_we    = 1'b1;
                mem_wdata = r_two ? 8'h00 : sha_pkg::PadByte;
                n_two     = 1'b1;
                n_fill    = r_fill + 6'd1;
                if (r_fill == 6'(sha_pkg::BlockBytes - 1)) begin
                    ctl.start = 1'b1;
                    n_state   = sha_pkg::ST_FOLD;
                end else if (r_fill == 6'(sha_pkg::LenOffset - 1)) begin
                    n_state = sha_pkg::ST_LEN;
                end
            end
            sha_pkg::ST_FOLD: begin
                // Overflow pad block compressing; zeros then length follow.
                if (sts.done) begin
                    n_state = sha_pkg::ST_PAD;
                end
            end
            sha_pkg::ST_LEN: begin
                mem_we    = 1'b1;
                mem_wdata = r_bits[8 * (7 - int'(r_fill[2:0])) +: 8];
                n_fill    = r_fill + 6'd1;
                if (r_fill == 6'(sha_pkg::BlockBytes - 1)) begin
                    ctl.start = 1'b1;
                    n_state   = sha_pkg::ST_LOAD;
                end
            end
            sha_pkg::ST_LOAD: begin
                if (sts.done) begin
                    n_state  = sha_pkg::ST_EMIT;
                    n_oidx   = 3'd0;
                    h_idx    = 3'd0;
                    n_ovalid = 1'b1;
                    n_oword  = h_word;
                    n_olast  = 1'b0;
                end
            end
            sha_pkg::ST_EMIT: begin
                if (o_out.ready) begin
                    if (r_olast) begin
                        n_ovalid = 1'b0;
                        restart  = 1'b1;
                        n_fill   = '0;
                        n_bits   = '0;
                        n_two    = 1'b0;
                        n_state  = sha_pkg::ST_IDLE;
                    end else begin
                        n_oidx  = r_oidx + 3'd1;
                        h_idx   = r_oidx + 3'd1;
                        n_oword = h_word;
                        n_olast = (r_oidx == 3'd6);
                    end
                end
            end
            default: begin
                n_state = sha_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sha_pkg::ST_IDLE;
            r_fill   <= '0;
            r_bits   <= '0;
            r_two    <= 1'b0;
            r_ovalid <= 1'b0;
            r_oidx   <= '0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_bits   <= n_bits;
            r_two    <= n_two;
            r_ovalid <= n_ovalid;
            r_oidx   <= n_oidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oword <= n_oword;
        r_olast <= n_olast;
    end

    assign o_out.valid = r_ovalid;
    assign o_out.data  = '{digest_word: r_oword, word_index: r_oidx, last_word: r_olast};

    `SHA_ASSERT_IMP(a_out_in_emit, i_clk, i_rst_n, r_ovalid, r_state == sha_pkg::ST_EMIT,
        "digest shown outside emit")
    `SHA_ASSERT_IMP(a_last_idx, i_clk, i_rst_n, r_ovalid && r_olast, r_oidx == 3'd7,
        "last word flag on wrong index")
    `SHA_ASSERT_IMP(a_no_in_busy, i_clk, i_rst_n, sts.busy, !in_fire,
        "input taken during compression")

endmodule

// ===== test/sha256_byte_stream_hasher_unit_tb.sv =====
`timescale 1ns / 100ps

module sha256_byte_stream_hasher_unit_tb;

    logic i_clk;
    logic i_rst_n;

    sha_stream_if #(.T(sha_pkg::t_in_item))  in_ch ();
    sha_stream_if #(.T(sha_pkg::t_out_item)) out_ch ();

    sha256_byte_stream_hasher_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // Round constants, written out here so the predictor stands on its own.
    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Predictor state: the running hash, the partial block and the bit count.
    logic [31:0] hash_state [8];
    logic [7:0]  blk_bytes [64];
    int unsigned blk_count;
    logic [63:0] bit_total;

    sha_pkg::t_in_item  pending_items [$];
    sha_pkg::t_out_item digest_queue [$];

    int unsigned n_errors   = 0;
    int unsigned n_sent     = 0;
    int unsigned n_words    = 0;
    int unsigned n_messages = 0;

    function automatic logic [31:0] rotr(logic [31:0] x, int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void compress_predicted();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (int i = 0; i < 64; i++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + K_TAB[i] + w[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endfunction

    function automatic void restart_predictor();
        for (int i = 0; i < 8; i++) hash_state[i] = H_INIT[i];
        blk_count = 0;
        bit_total = '0;
    endfunction

    // Absorbs one accepted item; on a last item the digest words are queued.
    function automatic void absorb_item(sha_pkg::t_in_item it);
        int unsigned p;
        sha_pkg::t_out_item r;
        if (it.byte_valid) begin
            blk_bytes[blk_count] = it.byte_value;
            blk_count++;
            bit_total += 64'd8;
            if (blk_count == 64) begin
                compress_predicted();
                blk_count = 0;
            end
        end
        if (!it.last) return;
        p = blk_count;
        blk_bytes[p] = sha_pkg::PadByte;
        p++;
        if (p > 56) begin
            while (p < 64) begin blk_bytes[p] = 8'h00; p++; end
            compress_predicted();
            p = 0;
        end
        while (p < 56) begin blk_bytes[p] = 8'h00; p++; end
        for (int i = 0; i < 8; i++) blk_bytes[56+i] = bit_total[63-8*i -: 8];
        compress_predicted();
        for (int i = 0; i < 8; i++) begin
            r.digest_word = hash_state[i];
            r.word_index  = 3'(i);
            r.last_word   = (i == 7);
            digest_queue.push_back(r);
        end
        restart_predictor();
    endfunction

    function automatic sha_pkg::t_in_item make_item(logic [7:0] v, logic bv, logic l);
        sha_pkg::t_in_item it;
        it.byte_value = v; it.byte_valid = bv; it.last = l;
        return it;
    endfunction

    // Queues a message of n random bytes; an empty final item is used at random, and always when n is 0.
    function automatic void queue_message(int unsigned n);
        bit empty_end;
        empty_end = (n == 0) || ($urandom_range(0, 3) == 0);
        for (int unsigned i = 0; i < n; i++)
            pending_items.push_back(make_item(8'($urandom), 1'b1,
                                              (!empty_end && i == n - 1)));
        if (empty_end) pending_items.push_back(make_item(8'($urandom), 1'b0, 1'b1));
    endfunction

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Sender: bursts of random length, sometimes separated by random gaps.
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                absorb_item(in_ch.data);
                n_sent++;
            end
            if (in_ch.valid && !in_ch.ready) begin
                // Held until the transfer completes.
            end else if (gap_left != 0) begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= pending_items.pop_front();
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                end else begin
                    burst_left--;
                    if (burst_left == 0 && $urandom_range(0, 1)) gap_left = $urandom_range(1, 6);
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: its own stall pattern, plus one long hold-off after the third message.
    int unsigned rx_cycle = 0;
    int unsigned hold_off = 0;
    bit          hold_done = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            rx_cycle++;
            if (!hold_done && n_messages >= 3) begin
                hold_done = 1'b1;
                hold_off  = 2000;
            end
            if (hold_off != 0) begin
                hold_off--;
                out_ch.ready <= 1'b0;
            end else if (rx_cycle % 200 < 100) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(0, 2) != 0);
            end
        end
    end

    // Monitor: every digest word transfer is checked against the oldest expectation.
    always @(posedge i_clk) begin
        sha_pkg::t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_words++;
            if (digest_queue.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected digest word %h index %0d", $time,
                         out_ch.data.digest_word, out_ch.data.word_index);
            end else begin
                want = digest_queue.pop_front();
                if (out_ch.data.digest_word !== want.digest_word) begin
                    n_errors++;
                    $display("%0t: digest_word expected %h actual %h", $time,
                             want.digest_word, out_ch.data.digest_word);
                end
                if (out_ch.data.word_index !== want.word_index) begin
                    n_errors++;
                    $display("%0t: word_index expected %0d actual %0d", $time,
                             want.word_index, out_ch.data.word_index);
                end
                if (out_ch.data.last_word !== want.last_word) begin
                    n_errors++;
                    $display("%0t: last_word expected %0b actual %0b", $time,
                             want.last_word, out_ch.data.last_word);
                end
                if (want.last_word) n_messages++;
            end
        end
    end

    initial begin
        int unsigned sz;
        restart_predictor();
        for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;

        // Directed part: the empty message, idle items, a byte carrying last,
        // and the all-ones and all-zero bytes.
        pending_items.push_back(make_item(8'h00, 1'b0, 1'b1));
        pending_items.push_back(make_item(8'hff, 1'b0, 1'b0));
        pending_items.push_back(make_item(8'hff, 1'b1, 1'b1));
        pending_items.push_back(make_item(8'h00, 1'b1, 1'b0));
        pending_items.push_back(make_item(8'h55, 1'b0, 1'b0));
        pending_items.push_back(make_item(8'haa, 1'b1, 1'b0));
        pending_items.push_back(make_item(8'h00, 1'b0, 1'b1));
        // The random part: about half the messages at the padding boundaries and
        // across full blocks, the rest short, with idle items sprinkled through.
        while (pending_items.size() < 430) begin
            case ($urandom_range(0, 5))
                0: sz = $urandom_range(55, 57);
                1: sz = $urandom_range(63, 65);
                2: sz = $urandom_range(119, 129);
                default: sz = $urandom_range(0, 20);
            endcase
            if ($urandom_range(0, 4) == 0)
                pending_items.push_back(make_item(8'($urandom), 1'b0, 1'b0));
            queue_message(sz);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_items.size() == 0 && !in_ch.valid);
        wait (digest_queue.size() == 0);
        repeat (400) @(posedge i_clk);
        $display("Sent %0d input items; checked %0d digest words over %0d messages.",
                 n_sent, n_words, n_messages);
        $display("Covered empty messages, idle items, padding boundaries and a long output stall.");
        if (n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Timeout with %0d digest words still expected.", digest_queue.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
